// ===== design/oscillator_discipline_stepper_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef OSCILLATOR_DISCIPLINE_STEPPER_MACROS_SVH
`define OSCILLATOR_DISCIPLINE_STEPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ODS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ods check failed");

// Next-cycle implication, disabled during reset.
`define ODS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ods check failed");

`endif

// ===== design/ods_pkg.sv =====
package ods_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int PADDR_W = 3;

  localparam logic [PADDR_W-3:0] REG_ALGORITHM = '0;

  typedef enum logic [1:0] {
    ALG_LOOP     = 2'd0,
    ALG_DRIFT    = 2'd1,
    ALG_WALK     = 2'd2,
    ALG_LOOP_ALT = 2'd3
  } algo_t;

  typedef enum logic [3:0] {
    TREND_NONE   = 4'd0,
    TREND_HIT    = 4'd1,
    TREND_HOLD   = 4'd2,
    TREND_VF_DN  = 4'd3,
    TREND_UF_DN  = 4'd4,
    TREND_VF_UP  = 4'd5,
    TREND_UF_UP  = 4'd6,
    TREND_C_DN   = 4'd7,
    TREND_F_DN   = 4'd8,
    TREND_C_UP   = 4'd9,
    TREND_F_UP   = 4'd10
  } trend_t;

  localparam int PERIOD_LOOP  = 429;
  localparam int PERIOD_DRIFT = 1000;
  localparam int PERIOD_WALK  = 5;

  // 1000 = 8 * 125: three low zero bits, then an odd factor
  localparam int DRIFT_TZ  = 3;
  localparam int DRIFT_ODD = PERIOD_DRIFT / 8;

  localparam logic [31:0] WALK_TAPS = 32'h8020_0003;

  // Inverse of an odd value modulo 2^32 (Newton iteration)
  function automatic logic [31:0] mod_inverse(input logic [31:0] a);
    logic [31:0] x;
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - a * x);
    end
    return x;
  endfunction

  // x is a multiple of odd n iff x * inv(n) mod 2^32 <= (2^32-1)/n
  localparam logic [31:0] INV_LOOP  = mod_inverse(32'(PERIOD_LOOP));
  localparam logic [31:0] INV_DRIFT = mod_inverse(32'(DRIFT_ODD));
  localparam logic [31:0] INV_WALK  = mod_inverse(32'(PERIOD_WALK));
  localparam logic [31:0] LIM_LOOP  = 32'(64'h0_FFFF_FFFF / PERIOD_LOOP);
  localparam logic [31:0] LIM_DRIFT = 32'(64'h0_FFFF_FFFF / DRIFT_ODD);
  localparam logic [31:0] LIM_WALK  = 32'(64'h0_FFFF_FFFF / PERIOD_WALK);

endpackage

// ===== design/ods_if.sv =====
interface ods_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        pps_count;
  logic               long_avg_ready;
  logic signed [20:0] offset_long_mhz;
  logic signed [20:0] offset_short_mhz;

  modport source (output valid, pps_count, long_avg_ready, offset_long_mhz,
                  offset_short_mhz, input ready);
  modport sink (input valid, pps_count, long_avg_ready, offset_long_mhz,
                offset_short_mhz, output ready);
endinterface

interface ods_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level_out;
  logic        update_tick;
  logic [3:0]  trend;
  logic        saturated;

  modport source (output valid, level_out, update_tick, trend, saturated,
                  input ready);
  modport sink (input valid, level_out, update_tick, trend, saturated,
                output ready);
endinterface

// ===== design/oscillator_discipline_stepper.sv =====
// Oscillator discipline stepper.
// in_ch carries one transaction per pulse-per-second tick (tick count,
// 1000 s and 100 s frequency offsets in mHz, long-average valid flag).
// out_ch returns exactly one transaction per tick: the control level after
// the tick, the update flag, a trend code and a saturation flag.
// The mode register (algorithm) sits on the APB port at byte address 0;
// pready is tied high. Write it only while no tick is in flight.
// A tick accepted on in_ch passes the input register, then the result
// register, before out_ch presents it. Throughput: one tick per cycle while
// out_ch is not stalled; the level update, LFSR step and period test all
// settle combinationally between the two registers, gated by one 32x32 multiply.
// A stalled out_ch holds its transaction; the input register still takes
// one more tick, then in_ch.ready drops until out_ch drains.
// Reset: level to midscale, LFSR to 1, mode to closed loop, both stages
// emptied.
module oscillator_discipline_stepper
  import ods_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ods_in_if.sink             in_ch,
  ods_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SUM_W = LEVEL_BITS + 2;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MID = {1'b1, {(LEVEL_BITS-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] LEVEL_MAX_S = {2'b00, {LEVEL_BITS{1'b1}}};

  algo_t                  algorithm;
  logic [LEVEL_BITS-1:0]  level;
  logic [LEVEL_BITS-1:0]  level_next;
  logic [31:0]            lfsr;
  logic [31:0]            lfsr_next;

  logic                   s1_valid;
  logic [31:0]            s1_count;
  logic                   s1_long_ok;
  logic signed [20:0]     s1_long;
  logic signed [20:0]     s1_short;

  logic                   out_valid;
  logic [15:0]            out_level;
  logic                   out_update;
  trend_t                 out_trend;
  logic                   out_sat;

  logic                   in_accept;
  logic                   s1_move;
  logic                   upd;
  trend_t                 trend_c;
  logic                   sat_c;

  function automatic logic [1:0] mod3(input logic [31:0] v);
    logic [5:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      s = s + 6'(v[2*i +: 2]);
    end
    t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
    u = 3'(t[1:0]) + 3'(t[3:2]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  // handshake
  assign s1_move     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_move;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid;
  assign out_ch.level_out   = out_level;
  assign out_ch.update_tick = out_update;
  assign out_ch.trend       = out_trend;
  assign out_ch.saturated   = out_sat;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_ALGORITHM) ? {30'd0, algorithm} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= ALG_LOOP;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_ALGORITHM) begin
      algorithm <= algo_t'(pwdata[1:0]);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_count   <= in_ch.pps_count;
      s1_long_ok <= in_ch.long_avg_ready;
      s1_long    <= in_ch.offset_long_mhz;
      s1_short   <= in_ch.offset_short_mhz;
    end
  end

  // step logic
  always_comb begin
    logic [31:0]             opnd;
    logic [31:0]             inv;
    logic [31:0]             lim;
    logic                    low_ok;
    logic [31:0]             prod;
    logic [31:0]             lfsr_adv;
    logic signed [7:0]       delta;
    logic signed [SUM_W-1:0] sum;

    case (algorithm)
      ALG_DRIFT: begin
        opnd   = {{DRIFT_TZ{1'b0}}, s1_count[31:DRIFT_TZ]};
        inv    = INV_DRIFT;
        lim    = LIM_DRIFT;
        low_ok = (s1_count[DRIFT_TZ-1:0] == '0);
      end
      ALG_WALK: begin
        opnd   = s1_count;
        inv    = INV_WALK;
        lim    = LIM_WALK;
        low_ok = 1'b1;
      end
      default: begin
        opnd   = s1_count;
        inv    = INV_LOOP;
        lim    = LIM_LOOP;
        low_ok = 1'b1;
      end
    endcase
    prod = 32'(opnd * inv);
    upd  = low_ok && (prod <= lim);

    lfsr_adv  = (lfsr >> 1) ^ (lfsr[0] ? WALK_TAPS : 32'd0);
    lfsr_next = lfsr;
    delta     = 8'sd0;
    trend_c   = TREND_NONE;

    case (algorithm)
      ALG_DRIFT: begin
        if (upd) begin
          delta = 8'sd1;
        end
      end
      ALG_WALK: begin
        if (upd) begin
          lfsr_next = lfsr_adv;
          delta     = $signed({6'd0, mod3(lfsr_adv)}) - 8'sd1;
        end
      end
      default: begin
        if (upd) begin
          if (s1_long_ok && s1_long >= -21'sd10 && s1_long <= 21'sd10) begin
            if (s1_long >= 21'sd5) begin
              delta = -8'sd5;  trend_c = TREND_VF_DN;
            end else if (s1_long >= 21'sd1) begin
              delta = -8'sd1;  trend_c = TREND_UF_DN;
            end else if (s1_long <= -21'sd5) begin
              delta = 8'sd5;   trend_c = TREND_VF_UP;
            end else if (s1_long <= -21'sd1) begin
              delta = 8'sd1;   trend_c = TREND_UF_UP;
            end else begin
              trend_c = TREND_HOLD;
            end
          end else if (s1_short >= 21'sd100) begin
            delta = -8'sd100;  trend_c = TREND_C_DN;
          end else if (s1_short >= 21'sd10) begin
            delta = -8'sd10;   trend_c = TREND_F_DN;
          end else if (s1_short <= -21'sd100) begin
            delta = 8'sd100;   trend_c = TREND_C_UP;
          end else if (s1_short <= -21'sd10) begin
            delta = 8'sd10;    trend_c = TREND_F_UP;
          end else begin
            trend_c = TREND_HIT;
          end
        end
      end
    endcase

    sum   = $signed({2'b00, level}) + SUM_W'(delta);
    sat_c = 1'b0;
    if (sum < 0) begin
      level_next = '0;
      sat_c      = 1'b1;
    end else if (sum > LEVEL_MAX_S) begin
      level_next = {LEVEL_BITS{1'b1}};
      sat_c      = 1'b1;
    end else begin
      level_next = sum[LEVEL_BITS-1:0];
    end
  end

  // state
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_MID;
      lfsr  <= 32'd1;
    end else if (s1_move) begin
      level <= level_next;
      lfsr  <= lfsr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_level  <= 16'(level_next);
      out_update <= upd;
      out_trend  <= trend_c;
      out_sat    <= sat_c;
    end
  end

endmodule

// ===== design/ods_checker.sv =====
`include "oscillator_discipline_stepper_macros.svh"

module ods_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] level_out,
  input logic        update_tick,
  input logic [3:0]  trend,
  input logic        saturated
);

  `ODS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(level_out) && $stable(trend))
  `ODS_ASSERT_NOW(a_trend_needs_update, clk, rst, out_valid && trend != 4'd0, update_tick)
  `ODS_ASSERT_NOW(a_sat_needs_update, clk, rst, out_valid && saturated, update_tick)
  `ODS_ASSERT_NOW(a_trend_range, clk, rst, out_valid, trend <= 4'd10)

endmodule

bind oscillator_discipline_stepper ods_checker u_ods_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .level_out   (out_ch.level_out),
  .update_tick (out_ch.update_tick),
  .trend       (out_ch.trend),
  .saturated   (out_ch.saturated)
);

// ===== bench/tb.sv =====
module tb;
  import ods_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LEVEL_TOP = (1 << LEVEL_BITS_DEF) - 1;

  typedef struct {
    logic [31:0]        count;
    logic               ready;
    logic signed [20:0] lng;
    logic signed [20:0] sht;
  } tick_t;

  typedef struct {
    logic [15:0] level;
    logic        upd;
    trend_t      trend;
    logic        sat;
  } outcome_t;

  class level_tracker;
    int          level;
    logic [31:0] lfsr;
    algo_t       mode;
    outcome_t    pending_levels[$];
    int          mismatches;

    function new();
      level = 1 << (LEVEL_BITS_DEF - 1);
      lfsr = 32'd1;
      mode = ALG_LOOP;
      mismatches = 0;
    endfunction

    function void set_mode(algo_t m);
      mode = m;
    endfunction

    function int pending();
      return pending_levels.size();
    endfunction

    function void note_tick(tick_t t);
      outcome_t o;
      int delta;
      int lng;
      int sht;
      int sum;
      logic out_bit;
      o.upd = 1'b0;
      o.sat = 1'b0;
      o.trend = TREND_NONE;
      delta = 0;
      lng = t.lng;
      sht = t.sht;
      case (mode)
        ALG_DRIFT: begin
          if (t.count % 32'(PERIOD_DRIFT) == 0) begin
            o.upd = 1'b1;
            delta = 1;
          end
        end
        ALG_WALK: begin
          if (t.count % 32'(PERIOD_WALK) == 0) begin
            o.upd = 1'b1;
            out_bit = lfsr[0];
            lfsr = lfsr >> 1;
            if (out_bit) lfsr = lfsr ^ WALK_TAPS;
            delta = int'(lfsr % 32'd3) - 1;
          end
        end
        default: begin
          if (t.count % 32'(PERIOD_LOOP) == 0) begin
            o.upd = 1'b1;
            if (t.ready && lng >= -10 && lng <= 10) begin
              if (lng >= 5) begin
                delta = -5;
                o.trend = TREND_VF_DN;
              end else if (lng >= 1) begin
                delta = -1;
                o.trend = TREND_UF_DN;
              end else if (lng <= -5) begin
                delta = 5;
                o.trend = TREND_VF_UP;
              end else if (lng <= -1) begin
                delta = 1;
                o.trend = TREND_UF_UP;
              end else begin
                o.trend = TREND_HOLD;
              end
            end else if (sht >= 100) begin
              delta = -100;
              o.trend = TREND_C_DN;
            end else if (sht >= 10) begin
              delta = -10;
              o.trend = TREND_F_DN;
            end else if (sht <= -100) begin
              delta = 100;
              o.trend = TREND_C_UP;
            end else if (sht <= -10) begin
              delta = 10;
              o.trend = TREND_F_UP;
            end else begin
              o.trend = TREND_HIT;
            end
          end
        end
      endcase
      if (delta != 0) begin
        sum = level + delta;
        if (sum < 0) begin
          sum = 0;
          o.sat = 1'b1;
        end else if (sum > LEVEL_TOP) begin
          sum = LEVEL_TOP;
          o.sat = 1'b1;
        end
        level = sum;
      end
      o.level = 16'(level);
      pending_levels.push_back(o);
    endfunction

    function void check_level(outcome_t got);
      outcome_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t unexpected transaction: level_out %0d", $time, got.level);
        mismatches++;
        return;
      end
      want = pending_levels.pop_front();
      if (got.level !== want.level) begin
        $display("%0t level_out expected %0d actual %0d", $time, want.level, got.level);
        mismatches++;
      end
      if (got.upd !== want.upd) begin
        $display("%0t update_tick expected %0d actual %0d", $time, want.upd, got.upd);
        mismatches++;
      end
      if (got.trend !== want.trend) begin
        $display("%0t trend expected %0d actual %0d", $time, want.trend, got.trend);
        mismatches++;
      end
      if (got.sat !== want.sat) begin
        $display("%0t saturated expected %0d actual %0d", $time, want.sat, got.sat);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic calm;
  int cycles;

  ods_in_if in_ch();
  ods_out_if out_ch();

  level_tracker tracker = new();

  oscillator_discipline_stepper DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.level = out_ch.level_out;
      got.upd = out_ch.update_tick;
      got.trend = trend_t'(out_ch.trend);
      got.sat = out_ch.saturated;
      tracker.check_level(got);
    end
  end

  // result-side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < 6) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic int period_of(algo_t m);
    case (m)
      ALG_DRIFT: return PERIOD_DRIFT;
      ALG_WALK:  return PERIOD_WALK;
      default:   return PERIOD_LOOP;
    endcase
  endfunction

  function automatic tick_t mk_tick(logic [31:0] count, logic ready, int lng, int sht);
    tick_t t;
    t.count = count;
    t.ready = ready;
    t.lng = 21'(lng);
    t.sht = 21'(sht);
    return t;
  endfunction

  function automatic int rand_offset();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 2000000) - 1000000;
      2: v = $urandom_range(0, 240) - 120;
      default: v = $urandom_range(0, 24) - 12;
    endcase
    return v;
  endfunction

  task automatic send_tick(tick_t t);
    if (!calm && $urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 18)) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.pps_count = t.count;
    in_ch.long_avg_ready = t.ready;
    in_ch.offset_long_mhz = t.lng;
    in_ch.offset_short_mhz = t.sht;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_tick(t);
  endtask

  task automatic write_mode(algo_t m);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_ALGORITHM, 2'b00};
    pwdata = 32'(m);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_mode(m);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(m)) begin
      $display("%0t algorithm readback expected %0d actual %0d", $time, m, prdata);
      tracker.mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    send_tick(mk_tick(32'd0, 1'b1, 0, 0));
    send_tick(mk_tick(32'd429, 1'b1, 10, 0));
    send_tick(mk_tick(32'd858, 1'b1, 5, 0));
    send_tick(mk_tick(32'd1287, 1'b1, 4, 0));
    send_tick(mk_tick(32'd1716, 1'b1, 1, 0));
    send_tick(mk_tick(32'd2145, 1'b1, -1, 0));
    send_tick(mk_tick(32'd2574, 1'b1, -4, 0));
    send_tick(mk_tick(32'd3003, 1'b1, -5, 0));
    send_tick(mk_tick(32'd3432, 1'b1, -10, 0));
    send_tick(mk_tick(32'd3861, 1'b1, 11, 0));
    send_tick(mk_tick(32'd4290, 1'b1, -11, 100));
    send_tick(mk_tick(32'd4719, 1'b0, 0, 99));
    send_tick(mk_tick(32'd5148, 1'b0, 0, 10));
    send_tick(mk_tick(32'd5577, 1'b0, 0, 9));
    send_tick(mk_tick(32'd6006, 1'b0, 0, -9));
    send_tick(mk_tick(32'd6435, 1'b0, 0, -10));
    send_tick(mk_tick(32'd6864, 1'b0, 0, -99));
    send_tick(mk_tick(32'd7293, 1'b0, 0, -100));
    send_tick(mk_tick(32'd7722, 1'b1, -1000000, 1000000));
    send_tick(mk_tick(32'd8151, 1'b1, 1000000, -1000000));
    // full-scale 21-bit patterns (minimum and maximum)
    send_tick(mk_tick(32'd8580, 1'b1, 32'h0010_0000, 32'h000F_FFFF));
    send_tick(mk_tick(32'd9009, 1'b1, 32'h000F_FFFF, 32'h0010_0000));
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, -1, -1));
    send_tick(mk_tick(32'd1, 1'b1, 0, 500));
    send_tick(mk_tick((32'hFFFF_FFFF / 32'd429) * 32'd429, 1'b0, 0, 0));
  endtask

  task automatic run_phase(algo_t m, int n, int upd_pct, bit push);
    tick_t t;
    int per;
    per = period_of(m);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < upd_pct)
        t.count = 32'($urandom_range(0, 32'hFFFF_FFFF / per)) * 32'(per);
      else
        t.count = $urandom;
      t.ready = 1'($urandom_range(0, 1));
      if (push && $urandom_range(0, 99) < 97) begin
        // steady coarse push toward the lower rail
        t.count = 32'($urandom_range(0, 32'hFFFF_FFFF / per)) * 32'(per);
        t.lng = $urandom_range(0, 1) ? 21'($urandom_range(11, 1000000))
                                     : 21'(-int'($urandom_range(11, 1000000)));
        t.sht = 21'($urandom_range(100, 1000000));
      end else begin
        t.lng = 21'(rand_offset());
        t.sht = 21'(rand_offset());
      end
      send_tick(t);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    cycles = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pps_count = '0;
    in_ch.long_avg_ready = 1'b0;
    in_ch.offset_long_mhz = '0;
    in_ch.offset_short_mhz = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_mode(ALG_LOOP);
    run_directed();
    drain();
    write_mode(ALG_LOOP_ALT);
    run_phase(ALG_LOOP_ALT, 360, 95, 1'b1);
    drain();
    write_mode(ALG_WALK);
    run_phase(ALG_WALK, 130, 70, 1'b0);
    drain();
    write_mode(ALG_DRIFT);
    run_phase(ALG_DRIFT, 80, 50, 1'b0);
    drain();
    write_mode(ALG_LOOP);
    run_phase(ALG_LOOP, 100, 70, 1'b0);
    drain();
    calm = 1'b1;
    write_mode(ALG_WALK);
    run_phase(ALG_WALK, 60, 80, 1'b0);
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/ods_pkg.sv
design/ods_if.sv
design/oscillator_discipline_stepper.sv
design/ods_checker.sv
bench/tb.sv
